// ===== hdl/run_length_region_moments_defines.svh =====
// Assertion macros for the run-length region moments block.
// Included by the files that carry concurrent assertions; depends on nothing else.
`ifndef RUN_LENGTH_REGION_MOMENTS_DEFINES_SVH
`define RUN_LENGTH_REGION_MOMENTS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RLRM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("run_length_region_moments: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RLRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("run_length_region_moments: next-cycle check failed");

`endif

// ===== hdl/rlrm_pkg.sv =====
// Shared types, constants and helper functions of the run-length region moments block.
// Depends on nothing; used by the top level and by rlrm_box.
package rlrm_pkg;

    localparam int COORD_BITS_DEF = 12;

    // Pixel count and maximum size register width, fixed by the interface.
    localparam int CNT_BITS = 25;
    localparam logic [CNT_BITS-1:0] COUNT_LIMIT    = 25'h100_0000;
    localparam logic [CNT_BITS-1:0] MAX_SIZE_RESET = 25'h100_0000;

    // Multiplicative inverse of three modulo any power of two, truncated where used.
    localparam logic [63:0] INV3_PATTERN = 64'hAAAA_AAAA_AAAA_AAAB;

    // Widest run length (coordinate width up to 16 plus one), rounded up to whole base-4 digits.
    localparam int MOD3_IN_BITS = 18;

    typedef struct packed {
        logic update;
        logic clear;
    } t_box_ctl;

    // Residue modulo three from the base-4 digit sum, since four leaves remainder one.
    function automatic logic [1:0] mod3(input logic [MOD3_IN_BITS-1:0] v);
        logic [4:0] s;
        logic [2:0] t;
        logic [1:0] r;
        s = '0;
        for (int i = 0; i < MOD3_IN_BITS / 2; i++) begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t inside {3'd0, 3'd3, 3'd6}) begin
            r = 2'd0;
        end else if (t inside {3'd1, 3'd4, 3'd7}) begin
            r = 2'd1;
        end else begin
            r = 2'd2;
        end
        return r;
    endfunction

endpackage

// ===== hdl/run_length_region_moments.sv =====
// Top level of the run-length region moments block; uses rlrm_pkg, rlrm_mul, rlrm_box.
// A run that adds moments occupies the block for its accept and nine sequencer steps
// around the shared multiplier; one that adds none for its accept only; a last run then
// waits in the closing step until the output register is free for its totals. No new run
// is taken until the sequencer is idle. Reset is synchronous, active low, clears all
// accumulators and the output valid, and loads max_size with 2^24; no clearing pass.
`include "run_length_region_moments_defines.svh"

module run_length_region_moments import rlrm_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration write port for max_size.
    input  logic                       i_cfg_we,
    input  logic [CNT_BITS-1:0]        i_cfg_wdata,
    // Run input channel.
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [COORD_BITS-1:0]      i_run_x,
    input  logic [COORD_BITS-1:0]      i_run_y,
    input  logic [COORD_BITS:0]        i_run_length,
    input  logic                       i_last_run,
    // Region result channel.
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [CNT_BITS-1:0]        o_pixel_count,
    output logic [COORD_BITS+23:0]     o_sum_x,
    output logic [COORD_BITS+23:0]     o_sum_y,
    output logic [2*COORD_BITS+23:0]   o_sum_xx,
    output logic [2*COORD_BITS+23:0]   o_sum_xy,
    output logic [2*COORD_BITS+23:0]   o_sum_yy,
    output logic [COORD_BITS-1:0]      o_box_left,
    output logic [COORD_BITS-1:0]      o_box_top,
    output logic [COORD_BITS:0]        o_box_width,
    output logic [COORD_BITS:0]        o_box_height,
    output logic                       o_oversize
);

    localparam int LEN_BITS  = COORD_BITS + 1;        // run length
    localparam int FAC_BITS  = COORD_BITS + 2;        // factor 2*len-1
    localparam int TRI_BITS  = 2 * COORD_BITS + 1;    // len*x, len*y, triangular number
    localparam int SUM1_BITS = 2 * COORD_BITS + 2;    // first moment of one run
    localparam int S1_BITS   = COORD_BITS + 24;
    localparam int S2_BITS   = 2 * COORD_BITS + 24;
    localparam int A_BITS    = 2 * COORD_BITS + 3;
    localparam int B_BITS    = FAC_BITS;
    localparam int P_BITS    = A_BITS + B_BITS;
    localparam int RAW_BITS  = CNT_BITS + 1;
    localparam logic [FAC_BITS-1:0] INV3 = INV3_PATTERN[FAC_BITS-1:0];

    // One-hot sequencer. The shared multiplier's product of one step is used in the next.
    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_DIV3  = 11'b000_0000_0010,
        S_MPAIR = 11'b000_0000_0100,
        S_SQ    = 11'b000_0000_1000,
        S_LX    = 11'b000_0001_0000,
        S_LY    = 11'b000_0010_0000,
        S_S2    = 11'b000_0100_0000,
        S_XY    = 11'b000_1000_0000,
        S_YY    = 11'b001_0000_0000,
        S_WB    = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    // Configuration and accumulators.
    logic [CNT_BITS-1:0] r_max_size;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic                r_over, n_over;
    logic [S1_BITS-1:0]  r_sumx, n_sumx;
    logic [S1_BITS-1:0]  r_sumy, n_sumy;
    logic [S2_BITS-1:0]  r_sumxx, n_sumxx;
    logic [S2_BITS-1:0]  r_sumxy, n_sumxy;
    logic [S2_BITS-1:0]  r_sumyy, n_sumyy;

    // The run being worked on and intermediate terms.
    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;
    logic [LEN_BITS-1:0]   r_len;
    logic                  r_last;
    logic [1:0]            r_mod3;
    logic [FAC_BITS-1:0]   r_fc;
    logic [TRI_BITS-1:0]   r_tri;
    logic [SUM1_BITS-1:0]  r_s1;
    logic [TRI_BITS-1:0]   r_ly;

    // Output register.
    logic                  r_out_valid;
    logic [CNT_BITS-1:0]   r_o_count;
    logic [S1_BITS-1:0]    r_o_sumx;
    logic [S1_BITS-1:0]    r_o_sumy;
    logic [S2_BITS-1:0]    r_o_sumxx;
    logic [S2_BITS-1:0]    r_o_sumxy;
    logic [S2_BITS-1:0]    r_o_sumyy;
    logic [COORD_BITS-1:0] r_o_left;
    logic [COORD_BITS-1:0] r_o_top;
    logic [LEN_BITS-1:0]   r_o_width;
    logic [LEN_BITS-1:0]   r_o_height;
    logic                  r_o_over;

    logic                  in_fire;
    logic                  done_fire;
    logic [RAW_BITS-1:0]   raw;
    logic                  over_in;
    logic                  add_in;
    logic [A_BITS-1:0]     mul_a;
    logic [B_BITS-1:0]     mul_b;
    logic [P_BITS-1:0]     r_prod;
    logic [LEN_BITS-1:0]   len_m1;
    logic [FAC_BITS-1:0]   fac_c;
    logic [LEN_BITS-1:0]   a_h;
    logic [LEN_BITS-1:0]   b_h;
    logic [FAC_BITS-1:0]   div3_in;
    logic [FAC_BITS-1:0]   quot3;
    logic [LEN_BITS-1:0]   fa;
    logic [LEN_BITS-1:0]   fb;
    logic [FAC_BITS-1:0]   fc;
    logic [TRI_BITS-1:0]   pair;
    logic [TRI_BITS-1:0]   tri_n;
    t_box_ctl              box_ctl;
    logic [COORD_BITS-1:0] box_left;
    logic [COORD_BITS-1:0] box_top;
    logic [LEN_BITS-1:0]   box_width;
    logic [LEN_BITS-1:0]   box_height;

    // Runs are taken only while the sequencer is idle. A finished result may still wait in
    // the output register meanwhile; only a last run waits for that register to free up.
    assign o_stall   = (r_state != S_IDLE);
    assign in_fire   = i_valid && (r_state == S_IDLE);
    assign done_fire = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    // The oversize decision uses the unsaturated count including this run.
    assign raw     = RAW_BITS'(r_count) + RAW_BITS'(i_run_length);
    assign over_in = r_over || (raw > RAW_BITS'(r_max_size));
    assign add_in  = !over_in && (i_run_length != '0);

    // The sum of squares 0..len-1 is (len-1)*len*(2len-1)/6. The even one of the first two
    // factors is halved, and the factor that three divides is divided exactly by multiplying
    // with the inverse of three. The same halved pair, times three where that pair took the
    // division, is the triangular number len*(len-1)/2.
    assign len_m1 = r_len - LEN_BITS'(1);
    assign fac_c  = {r_len, 1'b0} - FAC_BITS'(1);
    assign a_h    = r_len[0] ? (len_m1 >> 1) : len_m1;
    assign b_h    = r_len[0] ? r_len : (r_len >> 1);

    always_comb begin
        case (r_mod3)
            2'd0:    div3_in = FAC_BITS'(b_h);
            2'd1:    div3_in = FAC_BITS'(a_h);
            default: div3_in = fac_c;
        endcase
    end

    assign quot3 = r_prod[FAC_BITS-1:0];
    assign fa    = (r_mod3 == 2'd1) ? quot3[LEN_BITS-1:0] : a_h;
    assign fb    = (r_mod3 == 2'd0) ? quot3[LEN_BITS-1:0] : b_h;
    assign fc    = (r_mod3 == 2'd2) ? quot3 : fac_c;
    assign pair  = r_prod[TRI_BITS-1:0];
    assign tri_n = (r_mod3 == 2'd2) ? pair : pair + {pair[TRI_BITS-2:0], 1'b0};

    // Sequencer. Per run: sum x = len*x + tri, sum xx = x*(sum x + tri) + sq,
    // sum xy = y * sum x, sum y = len*y, sum yy = y*(len*y).
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_over  = r_over;
        n_sumx  = r_sumx;
        n_sumy  = r_sumy;
        n_sumxx = r_sumxx;
        n_sumxy = r_sumxy;
        n_sumyy = r_sumyy;
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_count = (raw > RAW_BITS'(COUNT_LIMIT)) ? COUNT_LIMIT
                                                             : raw[CNT_BITS-1:0];
                    n_over  = over_in;
                    if (add_in) begin
                        n_state = S_DIV3;
                    end else if (i_last_run) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV3: begin
                mul_a   = A_BITS'(div3_in);
                mul_b   = INV3;
                n_state = S_MPAIR;
            end
            S_MPAIR: begin
                mul_a   = A_BITS'(fa);
                mul_b   = B_BITS'(fb);
                n_state = S_SQ;
            end
            S_SQ: begin
                mul_a   = A_BITS'(pair);
                mul_b   = r_fc;
                n_state = S_LX;
            end
            S_LX: begin
                n_sumxx = r_sumxx + S2_BITS'(r_prod);
                mul_a   = A_BITS'(r_len);
                mul_b   = B_BITS'(r_x);
                n_state = S_LY;
            end
            S_LY: begin
                mul_a   = A_BITS'(r_len);
                mul_b   = B_BITS'(r_y);
                n_state = S_S2;
            end
            S_S2: begin
                n_sumy  = r_sumy + S1_BITS'(r_prod[TRI_BITS-1:0]);
                n_sumx  = r_sumx + S1_BITS'(r_s1);
                mul_a   = A_BITS'(r_s1) + A_BITS'(r_tri);
                mul_b   = B_BITS'(r_x);
                n_state = S_XY;
            end
            S_XY: begin
                n_sumxx = r_sumxx + S2_BITS'(r_prod);
                mul_a   = A_BITS'(r_s1);
                mul_b   = B_BITS'(r_y);
                n_state = S_YY;
            end
            S_YY: begin
                n_sumxy = r_sumxy + S2_BITS'(r_prod);
                mul_a   = A_BITS'(r_ly);
                mul_b   = B_BITS'(r_y);
                n_state = S_WB;
            end
            S_WB: begin
                n_sumyy = r_sumyy + S2_BITS'(r_prod);
                n_state = r_last ? S_DONE : S_IDLE;
            end
            S_DONE: begin
                // The totals move to the output register and the region starts afresh.
                if (done_fire) begin
                    n_count = '0;
                    n_over  = 1'b0;
                    n_sumx  = '0;
                    n_sumy  = '0;
                    n_sumxx = '0;
                    n_sumxy = '0;
                    n_sumyy = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_max_size <= MAX_SIZE_RESET;
            r_count    <= '0;
            r_over     <= 1'b0;
            r_sumx     <= '0;
            r_sumy     <= '0;
            r_sumxx    <= '0;
            r_sumxy    <= '0;
            r_sumyy    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_max_size <= i_cfg_wdata;
            end
            r_count <= n_count;
            r_over  <= n_over;
            r_sumx  <= n_sumx;
            r_sumy  <= n_sumy;
            r_sumxx <= n_sumxx;
            r_sumxy <= n_sumxy;
            r_sumyy <= n_sumyy;
        end
    end

    // Run payload and intermediate terms carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x    <= i_run_x;
            r_y    <= i_run_y;
            r_len  <= i_run_length;
            r_last <= i_last_run;
            r_mod3 <= mod3(MOD3_IN_BITS'(i_run_length));
        end
        if (r_state == S_MPAIR) begin
            r_fc <= fc;
        end
        if (r_state == S_SQ) begin
            r_tri <= tri_n;
        end
        if (r_state == S_LY) begin
            r_s1 <= SUM1_BITS'(r_prod[TRI_BITS-1:0]) + SUM1_BITS'(r_tri);
        end
        if (r_state == S_S2) begin
            r_ly <= r_prod[TRI_BITS-1:0];
        end
    end

    // Output register: loaded when the region closes, cleared when its beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_fire) begin
            r_o_count  <= r_count;
            r_o_sumx   <= r_sumx;
            r_o_sumy   <= r_sumy;
            r_o_sumxx  <= r_sumxx;
            r_o_sumxy  <= r_sumxy;
            r_o_sumyy  <= r_sumyy;
            r_o_left   <= box_left;
            r_o_top    <= box_top;
            r_o_width  <= box_width;
            r_o_height <= box_height;
            r_o_over   <= r_over;
        end
    end

    rlrm_mul #(
        .A_BITS (A_BITS),
        .B_BITS (B_BITS)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (r_prod)
    );

    // The box takes every accepted run, oversize or empty ones too.
    assign box_ctl.update = in_fire;
    assign box_ctl.clear  = done_fire;

    rlrm_box #(
        .COORD_BITS (COORD_BITS)
    ) u_box (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (box_ctl),
        .i_x      (i_run_x),
        .i_y      (i_run_y),
        .i_len    (i_run_length),
        .o_left   (box_left),
        .o_top    (box_top),
        .o_width  (box_width),
        .o_height (box_height)
    );

    assign o_valid       = r_out_valid;
    assign o_pixel_count = r_o_count;
    assign o_sum_x       = r_o_sumx;
    assign o_sum_y       = r_o_sumy;
    assign o_sum_xx      = r_o_sumxx;
    assign o_sum_xy      = r_o_sumxy;
    assign o_sum_yy      = r_o_sumyy;
    assign o_box_left    = r_o_left;
    assign o_box_top     = r_o_top;
    assign o_box_width   = r_o_width;
    assign o_box_height  = r_o_height;
    assign o_oversize    = r_o_over;

    // Closing a region fills the output register and returns the count and flag to zero.
    `RLRM_ASSERT_NEXT(a_done_clears, i_clk, i_rst_n, done_fire, r_out_valid && (r_count == '0) && !r_over)
    // Once a region is oversize its moments stay frozen until the region closes; checked on sum x, xx and yy.
    `RLRM_ASSERT_NEXT(a_over_freezes, i_clk, i_rst_n, r_over && (r_state != S_DONE), $stable(r_sumx) && $stable(r_sumxx) && $stable(r_sumyy))
    // A new result appears only out of the closing step.
    `RLRM_ASSERT_NOW(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_DONE))
    // The pixel count saturates at its limit.
    `RLRM_ASSERT_NOW(a_count_sat, i_clk, i_rst_n, 1'b1, r_count <= COUNT_LIMIT)

endmodule

// ===== hdl/rlrm_mul.sv =====
// Shared multiplier of the run-length region moments block, product registered.
// Depends on nothing; instanced once by the top level.
module rlrm_mul #(
    parameter int A_BITS = 27,
    parameter int B_BITS = 14
) (
    input  logic                     i_clk,
    input  logic [A_BITS-1:0]        i_a,
    input  logic [B_BITS-1:0]        i_b,
    output logic [A_BITS+B_BITS-1:0] o_p
);

    logic [A_BITS+B_BITS-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= (A_BITS+B_BITS)'(i_a) * (A_BITS+B_BITS)'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== hdl/rlrm_box.sv =====
// Bounding box tracker of the run-length region moments block.
// Depends on rlrm_pkg for the control struct.
module rlrm_box import rlrm_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_box_ctl              i_ctl,
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    input  logic [COORD_BITS:0]   i_len,
    output logic [COORD_BITS-1:0] o_left,
    output logic [COORD_BITS-1:0] o_top,
    output logic [COORD_BITS:0]   o_width,
    output logic [COORD_BITS:0]   o_height
);

    localparam int EXT_BITS = COORD_BITS + 1;

    logic [COORD_BITS-1:0] r_left;
    logic [COORD_BITS-1:0] r_top;
    logic [EXT_BITS-1:0]   r_right;
    logic [COORD_BITS-1:0] r_bottom;
    logic [EXT_BITS:0]     end_sum;
    logic [EXT_BITS-1:0]   end_sat;

    // The run end saturates to all ones when it does not fit.
    assign end_sum = (EXT_BITS+1)'(i_x) + (EXT_BITS+1)'(i_len);
    assign end_sat = end_sum[EXT_BITS] ? '1 : end_sum[EXT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_left   <= '1;
            r_top    <= '1;
            r_right  <= '0;
            r_bottom <= '0;
        end else if (i_ctl.update) begin
            if (i_x < r_left) begin
                r_left <= i_x;
            end
            if (i_y < r_top) begin
                r_top <= i_y;
            end
            if (end_sat > r_right) begin
                r_right <= end_sat;
            end
            if (i_y > r_bottom) begin
                r_bottom <= i_y;
            end
        end
    end

    assign o_left   = r_left;
    assign o_top    = r_top;
    assign o_width  = r_right - EXT_BITS'(r_left);
    assign o_height = EXT_BITS'(r_bottom) - EXT_BITS'(r_top) + EXT_BITS'(1);

endmodule
